@@ rtl/kalman_filter_two_state_macros.svh @@
// Assertion macros for the checker file.
`ifndef KALMAN_FILTER_TWO_STATE_MACROS_SVH
`define KALMAN_FILTER_TWO_STATE_MACROS_SVH
// Implication checked on every edge outside reset.
`define KF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication with the consequent checked at the next edge.
`define KF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/kf2s_pkg.sv @@
//------------------------------------------------------------------------------
// kf2s_pkg
// Types, constants and fixed point helpers for the two-state Kalman filter.
//------------------------------------------------------------------------------
package kf2s_pkg;

  localparam int WORD_W        = 32;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_STATE_ORD = 2;
  localparam int ACC_W         = 40;

  localparam logic [CFG_IDX_W-1:0] REG_TRANS0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RNOISE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAP0   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAP1   = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

  // divider control between sequencer and divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    begin
      hi = ACC_W'(signed'(33'sh0_7FFF_FFFF));
      lo = -hi - ACC_W'(1);
      if (v > hi) sat_word = 32'sh7FFF_FFFF;
      else if (v < lo) sat_word = 32'sh8000_0000;
      else sat_word = v[WORD_W-1:0];
    end
  endfunction

endpackage

@@ rtl/kf2s_div.sv @@
//------------------------------------------------------------------------------
// kf2s_div
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, den > 0, truncated
// toward zero and saturated to 32 bits. One quotient bit per cycle.
//------------------------------------------------------------------------------
module kf2s_div #(
  parameter int FRAC_BITS = kf2s_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [kf2s_pkg::WORD_W-1:0] num,
  input  logic signed [kf2s_pkg::WORD_W-1:0] den,
  output kf2s_pkg::div_ctl_t                 status,
  output logic signed [kf2s_pkg::WORD_W-1:0] quot
);
  import kf2s_pkg::*;

  localparam int DIVD_W = WORD_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] dvd;
  logic [DIVD_W-1:0] q;
  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic              busy;
  logic              done;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   shifted;
  logic              fits;
  logic [DIVD_W:0]   qmag;

  assign shifted = {rem[WORD_W-1:0], dvd[DIVD_W-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign fits    = !trial[WORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[WORD_W-1];
      dvd <= {(num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num)), {FRAC_BITS{1'b0}}};
      dsr <= den;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      rem <= fits ? trial : shifted;
      dvd <= {dvd[DIVD_W-2:0], 1'b0};
      q   <= {q[DIVD_W-2:0], fits};
    end
  end

  // magnitude of -2^31 fits as unsigned in the low word
  always_comb begin
    qmag = neg ? -{1'b0, q} : {1'b0, q};
    if (!neg && q > DIVD_W'(32'h7FFF_FFFF)) quot = 32'sh7FFF_FFFF;
    else if (neg && q > DIVD_W'(33'h0_8000_0000)) quot = 32'sh8000_0000;
    else quot = qmag[WORD_W-1:0];
  end

  assign status = '{start: start, busy: busy, done: done};

endmodule

@@ rtl/kalman_filter_two_state.sv @@
// Each transaction runs the 46-step product sequence on the shared multiplier,
// one gain division per state element (Q16.16 at the default FRAC_BITS of 16)
// and the finish steps; the divisions and finish steps are skipped when S <= 0.
// One transaction at a time; in_ready is low while busy and returns the cycle after
// the result is accepted.
// Synchronous reset clears state and covariance to zero, R to 1.0.
//------------------------------------------------------------------------------
// kalman_filter_two_state
// Two-state, scalar-measurement Kalman filter in signed fixed point.
//------------------------------------------------------------------------------
module kalman_filter_two_state #(
  parameter int FRAC_BITS   = kf2s_pkg::DEF_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [kf2s_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kf2s_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [kf2s_pkg::WORD_W-1:0]    control_value,
  input  logic signed [kf2s_pkg::WORD_W-1:0]    measured_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [kf2s_pkg::WORD_W-1:0]    estimate_first,
  output logic signed [kf2s_pkg::WORD_W-1:0]    estimate_second,
  output logic signed [kf2s_pkg::WORD_W-1:0]    cov_trace,
  output logic                                  gain_invalid
);
  import kf2s_pkg::*;

  localparam int PW   = 2 * WORD_W;
  // register file slots; slots below RF_LO are the config words
  localparam int NREG = 40;
  localparam int RW   = $clog2(NREG);
  localparam int RF_LO = 14;
  localparam int CW_IW = $clog2(RF_LO);
  localparam int NSTEP = 46;
  localparam int SW   = $clog2(NSTEP + 1);

  localparam logic signed [PW-1:0] P_MAX = PW'(33'sh0_7FFF_FFFF);
  localparam logic signed [PW-1:0] P_MIN = -P_MAX - PW'(1);

  // slot map
  localparam logic [RW-1:0] R_A00 = 0, R_A01 = 1, R_A10 = 2, R_A11 = 3;
  localparam logic [RW-1:0] R_B0 = 4, R_B1 = 5, R_C0 = 6, R_C1 = 7;
  localparam logic [RW-1:0] R_Q0 = 8, R_Q1 = 9;
  localparam logic [RW-1:0] R_U00 = 10, R_U01 = 11, R_U10 = 12, R_U11 = 13;
  localparam logic [RW-1:0] R_X0 = 14, R_X1 = 15;
  localparam logic [RW-1:0] R_P00 = 16, R_P01 = 17, R_P10 = 18, R_P11 = 19;
  localparam logic [RW-1:0] R_UV = 20, R_Z = 21, R_XP0 = 22, R_XP1 = 23;
  localparam logic [RW-1:0] R_T00 = 24, R_T01 = 25, R_T10 = 26, R_T11 = 27;
  localparam logic [RW-1:0] R_V00 = 28, R_V01 = 29, R_V10 = 30, R_V11 = 31;
  localparam logic [RW-1:0] R_PC0 = 32, R_PC1 = 33, R_CP0 = 34, R_CP1 = 35;
  localparam logic [RW-1:0] R_K0 = 36, R_K1 = 37, R_Y = 38, R_S = 39;
  localparam logic [RW-1:0] R_PP00 = R_P00, R_PP01 = R_P01;
  localparam logic [RW-1:0] R_PP10 = R_P10, R_PP11 = R_P11;

  // step kinds
  localparam logic [1:0] K_FIRST = 2'd0; // acc = product
  localparam logic [1:0] K_ADD   = 2'd1; // acc += product
  localparam logic [1:0] K_SUB   = 2'd2; // acc = dst - product
  localparam logic [1:0] K_DADD  = 2'd3; // acc = dst + product

  typedef struct packed {
    logic [RW-1:0] a;
    logic [RW-1:0] b;
    logic [RW-1:0] dst;
    logic [1:0]    kind;
    logic          wr;
  } step_t;

  // microcode: prediction (0..33), PC/CP (34..41), S (42..43), y (44..45)
  function automatic step_t prog(input logic [SW-1:0] i);
    step_t s;
    begin
      s = '{a: R_A00, b: R_A00, dst: R_A00, kind: K_FIRST, wr: 1'b0};
      case (i)
        0:  s = '{R_B0,  R_UV,  R_XP0, K_FIRST, 1'b0};
        1:  s = '{R_A00, R_X0,  R_XP0, K_ADD,   1'b0};
        2:  s = '{R_A01, R_X1,  R_XP0, K_ADD,   1'b1};
        3:  s = '{R_B1,  R_UV,  R_XP1, K_FIRST, 1'b0};
        4:  s = '{R_A10, R_X0,  R_XP1, K_ADD,   1'b0};
        5:  s = '{R_A11, R_X1,  R_XP1, K_ADD,   1'b1};
        6:  s = '{R_A00, R_P00, R_T00, K_FIRST, 1'b0};
        7:  s = '{R_A01, R_P10, R_T00, K_ADD,   1'b1};
        8:  s = '{R_A00, R_P01, R_T01, K_FIRST, 1'b0};
        9:  s = '{R_A01, R_P11, R_T01, K_ADD,   1'b1};
        10: s = '{R_A10, R_P00, R_T10, K_FIRST, 1'b0};
        11: s = '{R_A11, R_P10, R_T10, K_ADD,   1'b1};
        12: s = '{R_A10, R_P01, R_T11, K_FIRST, 1'b0};
        13: s = '{R_A11, R_P11, R_T11, K_ADD,   1'b1};
        14: s = '{R_U00, R_Q0,  R_V00, K_FIRST, 1'b1};
        15: s = '{R_U01, R_Q1,  R_V01, K_FIRST, 1'b1};
        16: s = '{R_U10, R_Q0,  R_V10, K_FIRST, 1'b1};
        17: s = '{R_U11, R_Q1,  R_V11, K_FIRST, 1'b1};
        // Pp(i,j) = sum_k T(i,k)A(j,k) + V(i,k)U(j,k); overwrites P
        18: s = '{R_T00, R_A00, R_PP00, K_FIRST, 1'b0};
        19: s = '{R_V00, R_U00, R_PP00, K_ADD,   1'b0};
        20: s = '{R_T01, R_A01, R_PP00, K_ADD,   1'b0};
        21: s = '{R_V01, R_U01, R_PP00, K_ADD,   1'b1};
        22: s = '{R_T00, R_A10, R_PP01, K_FIRST, 1'b0};
        23: s = '{R_V00, R_U10, R_PP01, K_ADD,   1'b0};
        24: s = '{R_T01, R_A11, R_PP01, K_ADD,   1'b0};
        25: s = '{R_V01, R_U11, R_PP01, K_ADD,   1'b1};
        26: s = '{R_T10, R_A00, R_PP10, K_FIRST, 1'b0};
        27: s = '{R_V10, R_U00, R_PP10, K_ADD,   1'b0};
        28: s = '{R_T11, R_A01, R_PP10, K_ADD,   1'b0};
        29: s = '{R_V11, R_U01, R_PP10, K_ADD,   1'b1};
        30: s = '{R_T10, R_A10, R_PP11, K_FIRST, 1'b0};
        31: s = '{R_V10, R_U10, R_PP11, K_ADD,   1'b0};
        32: s = '{R_T11, R_A11, R_PP11, K_ADD,   1'b0};
        33: s = '{R_V11, R_U11, R_PP11, K_ADD,   1'b1};
        34: s = '{R_PP00, R_C0, R_PC0, K_FIRST, 1'b0};
        35: s = '{R_PP01, R_C1, R_PC0, K_ADD,   1'b1};
        36: s = '{R_PP10, R_C0, R_PC1, K_FIRST, 1'b0};
        37: s = '{R_PP11, R_C1, R_PC1, K_ADD,   1'b1};
        38: s = '{R_C0, R_PP00, R_CP0, K_FIRST, 1'b0};
        39: s = '{R_C1, R_PP10, R_CP0, K_ADD,   1'b1};
        40: s = '{R_C0, R_PP01, R_CP1, K_FIRST, 1'b0};
        41: s = '{R_C1, R_PP11, R_CP1, K_ADD,   1'b1};
        42: s = '{R_C0, R_PC0,  R_S,   K_ADD,   1'b0};
        43: s = '{R_C1, R_PC1,  R_S,   K_ADD,   1'b1};
        44: s = '{R_C0, R_XP0,  R_Y,   K_FIRST, 1'b0};
        45: s = '{R_C1, R_XP1,  R_Y,   K_ADD,   1'b1};
        default: s = '{R_A00, R_A00, R_A00, K_FIRST, 1'b0};
      endcase
      prog = s;
    end
  endfunction

  // prediction, PC/CP, S and y run as steps 0..45, then division, then finish
  localparam int NMAC = 46;
  localparam int MW   = $clog2(NMAC + 1);
  // finish steps: x0, x1, P00, P01, P10, P11
  localparam int NFIN = 6;
  localparam int FW   = $clog2(NFIN + 1);

  logic signed [WORD_W-1:0] rf [RF_LO:NREG-1];
  logic signed [WORD_W-1:0] cw [RF_LO];
  logic [CFG_W-1:0]         cfg_trans0, cfg_trans1, cfg_ctrl, cfg_meas;
  logic [CFG_W-1:0]         cfg_noise, cfg_map0, cfg_map1;
  logic [WORD_W-2:0]        cfg_rnoise;

  state_t state, state_next;
  logic [MW-1:0]            pc;
  logic                     kidx;
  logic [FW-1:0]            fin;
  logic signed [ACC_W-1:0]  acc;
  logic                     invalid;
  logic                     s_bad;
  logic                     fin_mode;
  logic signed [WORD_W-1:0] est0, est1, trace;

  step_t                    cur;
  logic [RW-1:0]            op_a_sel, op_b_sel, dst_sel;
  logic [1:0]               op_kind;
  logic                     op_wr;
  logic signed [WORD_W-1:0] op_a, op_b;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     prod_r;
  logic signed [PW-1:0]     rnd;
  logic signed [PW-1:0]     shq;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_new;
  logic                     mac_go;
  logic                     stage_vld;
  logic [RW-1:0]            stage_dst;
  logic [1:0]               stage_kind;
  logic                     stage_wr;
  logic signed [WORD_W-1:0] stage_sub;
  logic                     issue;

  div_ctl_t                 div_st;
  logic                     div_start;
  logic signed [WORD_W-1:0] div_q;

  // ---------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_trans0 <= '0; cfg_trans1 <= '0; cfg_ctrl <= '0; cfg_meas <= '0;
      cfg_noise  <= '0; cfg_map0   <= '0; cfg_map1 <= '0;
      cfg_rnoise <= (WORD_W-1)'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRANS0: cfg_trans0 <= cfg_data;
        REG_TRANS1: cfg_trans1 <= cfg_data;
        REG_CTRL:   cfg_ctrl   <= cfg_data;
        REG_MEAS:   cfg_meas   <= cfg_data;
        REG_NOISE:  cfg_noise  <= cfg_data;
        REG_RNOISE: cfg_rnoise <= cfg_data[WORD_W-2:0];
        REG_MAP0:   cfg_map0   <= cfg_data;
        REG_MAP1:   cfg_map1   <= cfg_data;
        default: ;
      endcase
    end
  end

  // config words in slot order; config must only change while idle, the block does not enforce it
  assign cw = '{cfg_trans0[WORD_W-1:0], cfg_trans0[CFG_W-1:WORD_W],
                cfg_trans1[WORD_W-1:0], cfg_trans1[CFG_W-1:WORD_W],
                cfg_ctrl[WORD_W-1:0],   cfg_ctrl[CFG_W-1:WORD_W],
                cfg_meas[WORD_W-1:0],   cfg_meas[CFG_W-1:WORD_W],
                cfg_noise[WORD_W-1:0],  cfg_noise[CFG_W-1:WORD_W],
                cfg_map0[WORD_W-1:0],   cfg_map0[CFG_W-1:WORD_W],
                cfg_map1[WORD_W-1:0],   cfg_map1[CFG_W-1:WORD_W]};

  assign s_bad = (rf[R_S] <= 0);

  // ---------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_MAC;
      ST_MAC:  if (pc == MW'(NMAC) && !stage_vld) state_next = s_bad ? ST_DONE : ST_DIV;
      ST_DIV:  if (div_st.done && kidx) state_next = ST_DONE;
      ST_DONE: if ((fin == FW'(NFIN) || invalid) && !stage_vld) state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    fin_mode  = (state == ST_DONE);
    issue     = (state == ST_MAC && pc < MW'(NMAC)) ||
                (fin_mode && !invalid && fin < FW'(NFIN));
    div_start = (state == ST_MAC && pc == MW'(NMAC) && !stage_vld && !s_bad) ||
                (state == ST_DIV && div_st.done && !kidx);
  end

  // operand selection; state finish steps are dst + K*innov, covariance dst - K*cp
  always_comb begin
    cur      = prog(SW'(pc));
    op_a_sel = cur.a;
    op_b_sel = cur.b;
    dst_sel  = cur.dst;
    op_kind  = cur.kind;
    op_wr    = cur.wr;
    if (fin_mode) begin
      op_kind = (fin < FW'(2)) ? K_DADD : K_SUB;
      op_wr   = 1'b1;
      case (fin)
        0: begin op_a_sel = R_K0; op_b_sel = R_UV;  dst_sel = R_XP0; end
        1: begin op_a_sel = R_K1; op_b_sel = R_UV;  dst_sel = R_XP1; end
        2: begin op_a_sel = R_K0; op_b_sel = R_CP0; dst_sel = R_PP00; end
        3: begin op_a_sel = R_K0; op_b_sel = R_CP1; dst_sel = R_PP01; end
        4: begin op_a_sel = R_K1; op_b_sel = R_CP0; dst_sel = R_PP10; end
        default: begin op_a_sel = R_K1; op_b_sel = R_CP1; dst_sel = R_PP11; end
      endcase
    end
    op_a = (op_a_sel < R_X0) ? cw[op_a_sel[CW_IW-1:0]] : rf[op_a_sel];
    op_b = (op_b_sel < R_X0) ? cw[op_b_sel[CW_IW-1:0]] : rf[op_b_sel];
  end

  // shared multiplier, registered, then round/saturate/accumulate
  assign prod = PW'(op_a) * PW'(op_b);
  assign rnd  = prod_r + (PW'(1) <<< (FRAC_BITS - 1));
  assign shq  = rnd >>> FRAC_BITS;
  assign term = (shq > P_MAX) ? ACC_W'(P_MAX)
              : ((shq < P_MIN) ? ACC_W'(P_MIN) : ACC_W'(shq));

  always_comb begin
    case (stage_kind)
      K_FIRST: acc_new = term;
      K_ADD:   acc_new = acc + term;
      K_SUB:   acc_new = ACC_W'(stage_sub) - term;
      K_DADD:  acc_new = ACC_W'(stage_sub) + term;
      default: acc_new = term;
    endcase
  end

  assign mac_go = issue && (pc != MW'(NMAC) || fin_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stage_vld <= 1'b0;
      pc        <= '0;
      fin       <= '0;
      kidx      <= 1'b0;
      invalid   <= 1'b0;
      for (int i = 14; i < 20; i++) rf[i] <= '0;
    end else begin
      state     <= state_next;
      stage_vld <= mac_go;
      if (state == ST_IDLE && in_valid) begin
        pc   <= '0;
        fin  <= '0;
        kidx <= 1'b0;
        rf[R_UV] <= control_value;
        rf[R_Z]  <= measured_value;
        rf[R_S]  <= {1'b0, cfg_rnoise};
      end
      if (mac_go) begin
        if (fin_mode) fin <= fin + FW'(1);
        else pc <= pc + MW'(1);
        stage_sub <= rf[dst_sel];
      end
      if (stage_vld) begin
        acc <= acc_new;
        if (stage_wr) rf[stage_dst] <= sat_word(acc_new);
      end
      // innovation goes to UV slot before the state finish steps
      if (state == ST_MAC && pc == MW'(NMAC) && !stage_vld) begin
        invalid <= s_bad;
        rf[R_UV] <= sat_word(ACC_W'(rf[R_Z]) - ACC_W'(rf[R_Y]));
      end
      if (state == ST_DIV && div_st.done) begin
        if (kidx) rf[R_K1] <= div_q;
        else rf[R_K0] <= div_q;
        kidx <= 1'b1;
      end
      if (state == ST_DONE && (fin == FW'(NFIN) || invalid) && !stage_vld) begin
        for (int i = 0; i < 2; i++) rf[14 + i] <= rf[22 + i];
        est0  <= rf[R_XP0];
        est1  <= rf[R_XP1];
        trace <= sat_word(ACC_W'(rf[R_PP00]) + ACC_W'(rf[R_PP11]));
      end
    end
  end

  // S accumulates on top of R: first S step adds to the stored value
  always_ff @(posedge clk) begin
    if (mac_go) begin
      prod_r     <= prod;
      stage_dst  <= dst_sel;
      stage_wr   <= op_wr;
      stage_kind <= (!fin_mode && pc == MW'(42)) ? K_DADD : op_kind;
    end
  end

  kf2s_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    ((kidx || div_st.done) ? rf[R_PC1] : rf[R_PC0]),
    .den    (rf[R_S]),
    .status (div_st),
    .quot   (div_q)
  );

  assign estimate_first  = est0;
  assign estimate_second = est1;
  assign cov_trace       = trace;
  assign gain_invalid    = invalid;

endmodule

@@ rtl/kf2s_checker.sv @@
//------------------------------------------------------------------------------
// kf2s_checker
// Port-level checks on the two-state Kalman filter handshakes.
//------------------------------------------------------------------------------
`include "kalman_filter_two_state_macros.svh"
module kf2s_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic gain_invalid
);
  `KF_ASSERT_IMPL(a_excl, clk, rst, out_valid, !in_ready, "input taken while result pending")
  `KF_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "ready right after accept")
  `KF_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(gain_invalid), "result dropped")
endmodule

bind kalman_filter_two_state kf2s_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .gain_invalid(gain_invalid)
);
